[hw/rtl/bba_pkg.sv]
// Package for the bitmap block allocator: sizes, opcodes, status codes
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bba_pkg;

    localparam int BITMAP_BYTES = 64;
    localparam int TOTAL_BLOCKS = BITMAP_BYTES * 8;
    localparam int ADDR_W       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int TALLY_W      = $clog2(TOTAL_BLOCKS + 1);

    localparam int OPCODE_W = 1;
    localparam int BLOCK_W  = 9;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 10;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    // read address select
    localparam logic [1:0] RD_FIRST = 2'd0;
    localparam logic [1:0] RD_NEXT  = 2'd1;
    localparam logic [1:0] RD_FREE  = 2'd2;

    typedef struct packed {
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                num_load;
        logic                wr_alloc;
        logic                wr_free;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } bba_cmd_t;

    typedef struct packed {
        logic byte_full;
        logic addr_last;
        logic range_bad;
    } bba_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bba_if.sv]
// Request and response channel interfaces for the bitmap block allocator.
// Depends on bba_pkg.
`default_nettype none

interface bba_req_if;
    logic                            valid;
    logic                            ready;
    logic [bba_pkg::OPCODE_W-1:0]    opcode;
    logic [bba_pkg::BLOCK_W-1:0]     block_number;

    modport source (output valid, output opcode, output block_number, input ready);
    modport sink   (input valid, input opcode, input block_number, output ready);
endinterface

interface bba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bba_pkg::STATUS_W-1:0]    status;
    logic [bba_pkg::BLOCK_W-1:0]     granted_block;
    logic [bba_pkg::FREE_W-1:0]      free_blocks;

    modport source (output valid, output status, output granted_block,
                    output free_blocks, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input free_blocks, output ready);
endinterface

`default_nettype wire

[hw/rtl/bitmap_block_allocator.sv]
// Bitmap block allocator, first fit, top level.
// Depends on bba_pkg, bba_if, bba_ctrl and bba_datapath.
//
// Channels: req (opcode, block_number) in, rsp (status, granted_block,
// free_blocks) out, valid/ready handshake, one response per request.
// Allocate scans the 64-byte bitmap from byte 0, one memory read per
// cycle, until a byte with a clear bit is found or the last byte is
// read; the grant or the none-free status then goes to the response
// register. Free requests read and rewrite the addressed byte. The byte
// scan through the single memory read port sets the rate; a new request
// is taken in the cycle after the previous one completes.
// The response sits in an output register; a new request may be taken and
// scanned while it waits, but the result write-back is held until the
// receiver takes the pending response.
// Reset clears the controller, the per-byte valid bits (every block reads
// free) and sets the free count to 512; no clearing pass is needed.
`default_nettype none

module bitmap_block_allocator (
    input  wire logic clk,
    input  wire logic rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bba_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_block_number (req.block_number),
        .cmd             (cmd),
        .stat            (stat),
        .res_status      (rsp.status),
        .res_granted     (rsp.granted_block),
        .res_free        (rsp.free_blocks)
    );

endmodule

`default_nettype wire

[hw/rtl/bba_datapath.sv]
// Datapath: bitmap memory with per-byte valid bits, scan address, free
// tally and result registers. Depends on bba_pkg.
`default_nettype none

module bba_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bba_pkg::BLOCK_W-1:0]   in_block_number,
    input  wire bba_pkg::bba_cmd_t             cmd,
    output bba_pkg::bba_stat_t                 stat,
    output logic [bba_pkg::STATUS_W-1:0]       res_status,
    output logic [bba_pkg::BLOCK_W-1:0]        res_granted,
    output logic [bba_pkg::FREE_W-1:0]         res_free
);
    import bba_pkg::*;

    logic [7:0]              mem [BITMAP_BYTES];
    logic [BITMAP_BYTES-1:0] vld_reg;
    logic [7:0]              rd_data_reg;
    logic                    rd_vld_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [BLOCK_W-1:0]      num_reg;
    logic [TALLY_W-1:0]      tally_reg;
    logic [TALLY_W-1:0]      tally_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [BLOCK_W-1:0]      granted_reg;
    logic [FREE_W-1:0]       free_reg;

    logic [ADDR_W-1:0]       rd_addr;
    logic [31:0]             free_byte;
    logic [7:0]              cur_byte;
    logic [2:0]              bit_idx;
    logic [7:0]              wr_byte;
    logic                    freed_set;
    logic [31:0]             blk_ext;
    logic [31:0]             tally_ext;

    assign free_byte = 32'(in_block_number) >> 3;
    assign cur_byte  = rd_vld_reg ? rd_data_reg : 8'h00;
    assign freed_set = cur_byte[num_reg[2:0]];

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = addr_reg + ADDR_W'(1);
            RD_FREE:  rd_addr = free_byte[ADDR_W-1:0];
            default:  rd_addr = addr_reg;
        endcase
    end

    // lowest clear bit
    always_comb
    begin
        bit_idx = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (!cur_byte[b])
                bit_idx = 3'(b);
        end
    end

    always_comb
    begin
        if (cmd.wr_free)
            wr_byte = cur_byte & ~(8'h01 << num_reg[2:0]);
        else
            wr_byte = cur_byte | (8'h01 << bit_idx);
    end

    always_comb
    begin
        tally_next = tally_reg;
        if (cmd.wr_alloc && tally_reg != '0)
            tally_next = tally_reg - TALLY_W'(1);
        else if (cmd.wr_free && freed_set)
            tally_next = tally_reg + TALLY_W'(1);
    end

    assign stat.byte_full = (cur_byte == 8'hFF);
    assign stat.addr_last = (addr_reg == ADDR_W'(BITMAP_BYTES - 1));
    assign stat.range_bad = (32'(in_block_number) >= 32'(TOTAL_BLOCKS));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_alloc || cmd.wr_free)
            mem[addr_reg] <= wr_byte;
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            addr_reg    <= rd_addr;
        end
        if (cmd.num_load)
            num_reg <= in_block_number;
    end

    assign blk_ext   = 32'({addr_reg, bit_idx});
    assign tally_ext = 32'(tally_next);

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg  <= cmd.res_status;
            granted_reg <= (cmd.res_status == ST_ALLOCATED) ? blk_ext[BLOCK_W-1:0] : '0;
            free_reg    <= tally_ext[FREE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            tally_reg <= TALLY_W'(TOTAL_BLOCKS);
        end
        else
        begin
            if (cmd.wr_alloc || cmd.wr_free)
                vld_reg[addr_reg] <= 1'b1;
            tally_reg <= tally_next;
        end
    end

    assign res_status  = status_reg;
    assign res_granted = granted_reg;
    assign res_free    = free_reg;

endmodule

`default_nettype wire

[hw/rtl/bba_ctrl.sv]
// Controller: sequences request acceptance, byte scan, read-modify-write
// and result handoff. Depends on bba_pkg.
`default_nettype none

module bba_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [bba_pkg::OPCODE_W-1:0]  in_opcode,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    input  wire bba_pkg::bba_stat_t            stat,
    output bba_pkg::bba_cmd_t                  cmd
);
    import bba_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FREE  = 2'd2;
    localparam logic [1:0] S_RANGE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_ok;

    assign slot_ok  = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_FIRST;
        cmd.res_status = ST_ALLOCATED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.num_load = 1'b1;
                    if (in_opcode == OP_ALLOC)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_FIRST;
                        state_next = S_SCAN;
                    end
                    else if (stat.range_bad)
                        state_next = S_RANGE;
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_FREE;
                        state_next = S_FREE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!stat.byte_full)
                begin
                    if (slot_ok)
                    begin
                        cmd.wr_alloc   = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_ALLOCATED;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.addr_last)
                begin
                    if (slot_ok)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NONE_FREE;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_FREE:
            begin
                if (slot_ok)
                begin
                    cmd.wr_free    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FREED;
                    state_next     = S_IDLE;
                end
            end
            S_RANGE:
            begin
                if (slot_ok)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_RANGE;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
